[design/dkhf_pkg.sv]
// ----------------------------------------------------------------------------
// dkhf_pkg
// shared types and constants of the duplicate key hash filter
// ----------------------------------------------------------------------------
package dkhf_pkg;

	localparam int MAX_BUCKETS = 65536;
	localparam int WAYS        = 8;
	localparam int WAY_W       = $clog2(WAYS);
	localparam int IDX_W       = $clog2(MAX_BUCKETS);
	localparam int BC_W        = IDX_W + 1;
	localparam int HASH_W      = 32;
	localparam int FP_W        = 64;
	localparam int PROD_W      = HASH_W + BC_W;
	localparam int ADDR_W      = 4;
	localparam int DATA_W      = 32;

	localparam logic [HASH_W-1:0] HASH_MUL_EVEN = 32'h5a827999;
	localparam logic [HASH_W-1:0] HASH_MUL_ODD  = 32'h6ed9eba1;
	localparam logic [7:0]        LONG_MARK     = 8'h80;

	localparam logic [BC_W-1:0] BC_MAX = BC_W'(MAX_BUCKETS);

	// register indexes, taken from paddr[3:2]
	localparam logic [1:0] REG_BUCKET_COUNT  = 2'd0;
	localparam logic [1:0] REG_LOCK_HALF     = 2'd1;
	localparam logic [1:0] REG_UPDATE_ENABLE = 2'd2;

	typedef logic [WAYS-1:0][FP_W-1:0] row_t;

	typedef struct packed {
		logic [BC_W-1:0] bucket_count;
		logic            lock_half;
		logic            update_enable;
	} cfg_t;

	// controller to datapath
	typedef struct packed {
		logic             take_byte;
		logic             calc_idx;
		logic             rd;
		logic             upd;
		logic             clr_wr;
		logic [IDX_W-1:0] clr_addr;
	} cmd_t;

endpackage

[design/dkhf_if.sv]
// ----------------------------------------------------------------------------
// dkhf_if
// valid/ready channels for key bytes and filter results
// ----------------------------------------------------------------------------
interface dkhf_key_if;
	logic       valid;
	logic       ready;
	logic [7:0] key_byte;
	logic       last_byte;

	modport source (output valid, output key_byte, output last_byte, input ready);
	modport sink   (input valid, input key_byte, input last_byte, output ready);
endinterface

interface dkhf_res_if;
	logic                      valid;
	logic                      ready;
	logic                      is_duplicate;
	logic [dkhf_pkg::IDX_W-1:0] bucket_index;

	modport source (output valid, output is_duplicate, output bucket_index, input ready);
	modport sink   (input valid, input is_duplicate, input bucket_index, output ready);
endinterface

[design/dkhf_cfg.sv]
// ----------------------------------------------------------------------------
// dkhf_cfg
// apb register bank: bucket count, lock half, update enable
// ----------------------------------------------------------------------------
module dkhf_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [dkhf_pkg::ADDR_W-1:0]   paddr,
	input  logic [dkhf_pkg::DATA_W-1:0]   pwdata,
	output logic [dkhf_pkg::DATA_W-1:0]   prdata,
	output logic                          pready,
	output dkhf_pkg::cfg_t                cfg
);
	import dkhf_pkg::*;

	cfg_t            cfg_q;
	logic            wr;
	logic [BC_W-1:0] bc_wr;

	assign pready = 1'b1;
	assign wr     = psel & penable & pwrite;
	// saturate bucket count above the maximum
	assign bc_wr  = (pwdata[BC_W-1:0] > BC_MAX) ? BC_MAX : pwdata[BC_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.bucket_count  <= BC_MAX;
			cfg_q.lock_half     <= 1'b1;
			cfg_q.update_enable <= 1'b1;
		end else if (wr) begin
			unique case (paddr[3:2])
				REG_BUCKET_COUNT:  cfg_q.bucket_count  <= bc_wr;
				REG_LOCK_HALF:     cfg_q.lock_half     <= pwdata[0];
				REG_UPDATE_ENABLE: cfg_q.update_enable <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_BUCKET_COUNT:  prdata = DATA_W'(cfg_q.bucket_count);
			REG_LOCK_HALF:     prdata = DATA_W'(cfg_q.lock_half);
			REG_UPDATE_ENABLE: prdata = DATA_W'(cfg_q.update_enable);
			default:           prdata = '0;
		endcase
	end

	assign cfg = cfg_q;
endmodule

[design/dkhf_ctrl.sv]
// ----------------------------------------------------------------------------
// dkhf_ctrl
// sequencer: store clearing, byte intake, index, bucket read, update
// ----------------------------------------------------------------------------
module dkhf_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  logic           in_last,
	output logic           in_ready,
	input  logic           out_ready,
	output logic           out_valid,
	output dkhf_pkg::cmd_t cmd
);
	import dkhf_pkg::*;

	typedef enum logic [4:0] {
		S_CLEAR = 5'b00001,
		S_IDLE  = 5'b00010,
		S_IDX   = 5'b00100,
		S_READ  = 5'b01000,
		S_UPD   = 5'b10000
	} state_t;

	state_t           state_q, state_n;
	logic [IDX_W-1:0] clr_q;
	logic             out_valid_q;
	logic             out_free;

	assign out_free = ~out_valid_q | out_ready;
	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_n          = state_q;
		cmd.take_byte    = 1'b0;
		cmd.calc_idx     = 1'b0;
		cmd.rd           = 1'b0;
		cmd.upd          = 1'b0;
		cmd.clr_wr       = 1'b0;
		cmd.clr_addr     = clr_q;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clr_wr = 1'b1;
				if (clr_q == '1) state_n = S_IDLE;
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.take_byte = 1'b1;
					if (in_last) state_n = S_IDX;
				end
			end
			S_IDX: begin
				cmd.calc_idx = 1'b1;
				state_n      = S_READ;
			end
			S_READ: begin
				cmd.rd  = 1'b1;
				state_n = S_UPD;
			end
			S_UPD: begin
				if (out_free) begin
					cmd.upd = 1'b1;
					state_n = S_IDLE;
				end
			end
			default: state_n = S_CLEAR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (state_q == S_CLEAR) clr_q <= clr_q + 1'b1;
			if (cmd.upd) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
endmodule

[design/dkhf_dp.sv]
// ----------------------------------------------------------------------------
// dkhf_dp
// hash and fingerprint registers, index multiply, bucket store and update
// ----------------------------------------------------------------------------
module dkhf_dp (
	input  logic                        clk,
	input  logic                        arst_n,
	input  dkhf_pkg::cfg_t              cfg,
	input  dkhf_pkg::cmd_t              cmd,
	input  logic [7:0]                  key_byte,
	output logic                        is_duplicate,
	output logic [dkhf_pkg::IDX_W-1:0]  bucket_index
);
	import dkhf_pkg::*;

	// running key state
	logic [HASH_W-1:0] even_q, odd_q;
	logic [FP_W-1:0]   fp_q;
	logic [2:0]        off_q;
	logic              started_q, long_q;

	// key end
	logic [FP_W-1:0]   fpk_q;
	logic [IDX_W-1:0]  idx_q;
	row_t              row_q;
	logic              dup_q;
	logic [IDX_W-1:0]  bidx_q;

	row_t              mem [MAX_BUCKETS];

	// byte step
	logic              use_byte, fold;
	logic [HASH_W-1:0] h_opnd, h_mul, h_prod;
	logic [FP_W-1:0]   fp_sum, fp_lane, fp_n;
	logic [HASH_W-1:0] h_key;
	logic [PROD_W-1:0] idx_prod;

	assign use_byte = cmd.take_byte & (key_byte != 8'd0);
	assign fold     = (off_q == 3'd0) & started_q;
	assign h_opnd   = (off_q[0] ? odd_q : even_q) + HASH_W'(key_byte);
	assign h_mul    = off_q[0] ? HASH_MUL_ODD : HASH_MUL_EVEN;
	assign h_prod   = h_opnd * h_mul;
	assign fp_sum   = fold ? (fp_q + {even_q, odd_q}) : fp_q;
	assign fp_lane  = FP_W'(key_byte) << {off_q, 3'b000};
	assign fp_n     = fp_sum ^ fp_lane;

	assign h_key    = even_q ^ odd_q;
	assign idx_prod = PROD_W'(h_key) * PROD_W'(cfg.bucket_count);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			even_q    <= '0;
			odd_q     <= '0;
			fp_q      <= FP_W'(1);
			off_q     <= '0;
			started_q <= 1'b0;
			long_q    <= 1'b0;
		end else if (cmd.calc_idx) begin
			even_q    <= '0;
			odd_q     <= '0;
			fp_q      <= FP_W'(1);
			off_q     <= '0;
			started_q <= 1'b0;
			long_q    <= 1'b0;
		end else if (use_byte) begin
			if (off_q[0]) odd_q <= h_prod;
			else even_q <= h_prod;
			fp_q      <= fp_n;
			off_q     <= off_q + 3'd1;
			started_q <= 1'b1;
			if (fold) long_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.calc_idx) begin
			idx_q <= idx_prod[HASH_W +: IDX_W];
			fpk_q <= long_q ? (fp_q | {LONG_MARK, {(FP_W-8){1'b0}}}) : fp_q;
		end
	end

	// bucket search and replacement
	logic [WAY_W-1:0] lock;
	logic [WAYS-1:0]  nz;
	logic             done, hit, has_empty;
	logic [WAY_W-1:0] hit_idx, emp_idx;
	row_t             row_n;

	assign lock = cfg.lock_half ? WAY_W'(WAYS / 2) : '0;

	always_comb begin
		done      = 1'b0;
		hit       = 1'b0;
		has_empty = 1'b0;
		hit_idx   = '0;
		emp_idx   = '0;
		for (int k = 0; k < WAYS; k++) begin
			nz[k] = (row_q[k] != '0);
		end
		for (int k = 0; k < WAYS; k++) begin
			if (!done) begin
				if (!nz[k]) begin
					done      = 1'b1;
					has_empty = 1'b1;
					emp_idx   = WAY_W'(k);
				end else if (row_q[k] == fpk_q) begin
					done    = 1'b1;
					hit     = 1'b1;
					hit_idx = WAY_W'(k);
				end
			end
		end
		row_n = row_q;
		if (cfg.update_enable) begin
			if (hit) begin
				// promote one slot later, outside the locked half
				for (int k = 0; k < WAYS - 1; k++) begin
					if (hit_idx == WAY_W'(k) && WAY_W'(k) >= lock && nz[k+1]) begin
						row_n[k]   = row_q[k+1];
						row_n[k+1] = fpk_q;
					end
				end
			end else if (has_empty) begin
				for (int k = 0; k < WAYS; k++) begin
					if (emp_idx == WAY_W'(k)) row_n[k] = fpk_q;
				end
			end else begin
				// full bucket: shift unlocked slots down, oldest drops out
				for (int k = 0; k < WAYS - 1; k++) begin
					if (WAY_W'(k) >= lock) row_n[k] = row_q[k+1];
				end
				row_n[WAYS-1] = fpk_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.clr_wr) mem[cmd.clr_addr] <= '0;
		else if (cmd.upd) mem[idx_q] <= row_n;
		if (cmd.rd) row_q <= mem[idx_q];
	end

	always_ff @(posedge clk) begin
		if (cmd.upd) begin
			dup_q  <= hit;
			bidx_q <= idx_q;
		end
	end

	assign is_duplicate = dup_q;
	assign bucket_index = bidx_q;
endmodule

[design/duplicate_key_hash_filter.sv]
// ----------------------------------------------------------------------------
// duplicate_key_hash_filter
// byte-serial key hashing with an 8-way set associative duplicate filter
// ----------------------------------------------------------------------------
// result: after the last key byte's transfer the index multiply, bucket read
//   and bucket update states follow; the update waits while a result is held
// throughput: one key byte per cycle while the sequencer is idle; the bucket
//   read-modify-write goes through the single store port
// reset: bucket_count 65536, lock_half 1, update_enable 1, then a clearing
//   pass zeroes the 65536 bucket rows before bytes are taken
module duplicate_key_hash_filter (
	input  logic                        clk,
	input  logic                        arst_n,
	dkhf_key_if.sink                    key_ch,
	dkhf_res_if.source                  res_ch,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [dkhf_pkg::ADDR_W-1:0] paddr,
	input  logic [dkhf_pkg::DATA_W-1:0] pwdata,
	output logic [dkhf_pkg::DATA_W-1:0] prdata,
	output logic                        pready
);
	import dkhf_pkg::*;

	cfg_t cfg;
	cmd_t cmd;

	// register bank; writes are served during the clearing pass too
	dkhf_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// sequencer: owns the handshakes and the output valid flag, so a
	// finished result can wait while the next key streams in
	dkhf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (key_ch.valid),
		.in_last   (key_ch.last_byte),
		.in_ready  (key_ch.ready),
		.out_ready (res_ch.ready),
		.out_valid (res_ch.valid),
		.cmd       (cmd)
	);

	// hashes, fingerprint, bucket store and the result register
	dkhf_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.cmd          (cmd),
		.key_byte     (key_ch.key_byte),
		.is_duplicate (res_ch.is_duplicate),
		.bucket_index (res_ch.bucket_index)
	);
endmodule

[tb/sv/duplicate_key_hash_filter_test.sv]
// ----------------------------------------------------------------------------
// duplicate_key_hash_filter_test
// self-checking bench: keys go in byte by byte, each verdict not typed in is
// compared against an in-bench mirror of the hashes and the bucket store,
// across several register settings, with random stalls on both channels
// ----------------------------------------------------------------------------
module duplicate_key_hash_filter_test;
	import dkhf_pkg::*;

	localparam int POOL_KEYS = 32;
	localparam int KEY_MAX   = 20;
	localparam int MAX_WAIT  = 12;
	localparam int LONG_HOLD = 400;

	// one expected filter verdict
	typedef struct packed {
		logic             is_duplicate;
		logic [IDX_W-1:0] bucket_index;
	} verdict_t;

	// directed row; verdict typed in only where fixed is set
	typedef struct packed {
		logic [7:0]       key_byte;
		logic             last_byte;
		logic             fixed;
		logic             is_duplicate;
		logic [IDX_W-1:0] bucket_index;
	} directed_row_t;

	// one register setting followed by a burst of random keys
	typedef struct packed {
		logic [31:0] bucket_count;
		logic        lock_half;
		logic        update_enable;
		logic [15:0] items;
		logic        squeeze;
	} setting_t;

	logic clk = 1'b0;
	logic arst_n;

	dkhf_key_if key_if ();
	dkhf_res_if res_if ();

	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [ADDR_W-1:0]   paddr;
	logic [DATA_W-1:0]   pwdata;
	logic [DATA_W-1:0]   prdata;
	logic                pready;

	duplicate_key_hash_filter dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.key_ch  (key_if),
		.res_ch  (res_if),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always #5 clk = ~clk;

	// ------------------------------------------------------------------
	// mirror of the filter: register copies, running key state, store
	// ------------------------------------------------------------------
	logic [BC_W-1:0]   cfg_bucket_count;
	logic              cfg_lock_half;
	logic              cfg_update_enable;

	logic [HASH_W-1:0] hash_even;
	logic [HASH_W-1:0] hash_odd;
	logic [FP_W-1:0]   key_fp;
	logic [2:0]        lane;
	logic              key_started;
	logic              key_long;

	// sparse copy of the bucket rows, absent entry means empty slot
	logic [FP_W-1:0]   bucket_mirror [int unsigned];

	verdict_t          pending_verdicts [$];

	// key pool, so that keys come back and hit
	logic [7:0]        pool_key [POOL_KEYS][KEY_MAX];
	int                pool_len [POOL_KEYS];
	int                pool_fill;
	logic [8:0]        key_seq [$];   // {last_byte, key_byte}

	int errors;
	int bytes_sent;
	int verdicts_seen;
	int dups_seen;
	int settings_run;

	// handshake shaping
	int hold_cycles;
	int squeeze_left;
	bit send_calm;
	bit take_calm;
	int send_count;
	int take_count;

	directed_row_t directed_rows [25] = '{
		// empty key right after reset: hash 0, bucket 0, new
		'{8'h00, 1'b1, 1'b1, 1'b0, 16'h0000},
		// empty key again: found
		'{8'h00, 1'b1, 1'b1, 1'b1, 16'h0000},
		// single 0x01 cancels the starting fingerprint to zero: never found
		'{8'h01, 1'b1, 1'b1, 1'b0, 16'h5a82},
		'{8'h01, 1'b1, 1'b1, 1'b0, 16'h5a82},
		// lone zero byte without last mark is dropped
		'{8'h00, 1'b0, 1'b0, 1'b0, 16'h0000},
		'{8'hff, 1'b1, 1'b0, 1'b0, 16'h0000},
		'{8'hff, 1'b1, 1'b0, 1'b0, 16'h0000},
		// nine real bytes with a zero filler: long key, one fold
		'{8'hff, 1'b0, 1'b0, 1'b0, 16'h0000},
		'{8'h80, 1'b0, 1'b0, 1'b0, 16'h0000},
		'{8'h7f, 1'b0, 1'b0, 1'b0, 16'h0000},
		'{8'h00, 1'b0, 1'b0, 1'b0, 16'h0000},
		'{8'h55, 1'b0, 1'b0, 1'b0, 16'h0000},
		'{8'haa, 1'b0, 1'b0, 1'b0, 16'h0000},
		'{8'h01, 1'b0, 1'b0, 1'b0, 16'h0000},
		'{8'hfe, 1'b0, 1'b0, 1'b0, 16'h0000},
		'{8'h02, 1'b0, 1'b0, 1'b0, 16'h0000},
		'{8'h40, 1'b1, 1'b0, 1'b0, 16'h0000},
		// key closed by a zero byte carrying the last mark
		'{8'h12, 1'b0, 1'b0, 1'b0, 16'h0000},
		'{8'h34, 1'b0, 1'b0, 1'b0, 16'h0000},
		'{8'h00, 1'b1, 1'b0, 1'b0, 16'h0000},
		// same key closed normally
		'{8'h12, 1'b0, 1'b0, 1'b0, 16'h0000},
		'{8'h34, 1'b1, 1'b0, 1'b0, 16'h0000},
		'{8'h80, 1'b1, 1'b0, 1'b0, 16'h0000},
		'{8'h80, 1'b1, 1'b0, 1'b0, 16'h0000},
		// empty key sits in a locked slot of bucket 0
		'{8'h00, 1'b1, 1'b1, 1'b1, 16'h0000}
	};

	// bucket 2..16 for the sixth setting is drawn at run time
	setting_t plan [7] = '{
		'{32'd1,          1'b1, 1'b1, 16'd110, 1'b0},
		'{32'd1,          1'b0, 1'b1, 16'd110, 1'b0},
		'{32'd2,          1'b0, 1'b0, 16'd80,  1'b0},
		'{32'hffff_ffff,  1'b1, 1'b1, 16'd110, 1'b1},
		'{32'd0,          1'b0, 1'b1, 16'd90,  1'b0},
		'{32'd4,          1'b1, 1'b1, 16'd100, 1'b0},
		'{32'd65536,      1'b0, 1'b1, 16'd90,  1'b1}
	};

	task automatic report(input string what);
		errors++;
		if (errors <= 30)
			$display("mismatch at %0t: %s", $time, what);
	endtask

	function automatic void clear_key();
		hash_even   = '0;
		hash_odd    = '0;
		key_fp      = 64'd1;
		lane        = '0;
		key_started = 1'b0;
		key_long    = 1'b0;
	endfunction

	function automatic void absorb_key_byte(input logic [7:0] b);
		// fold the running hashes in before each new group of eight
		if (lane == 3'd0 && key_started) begin
			key_fp   = key_fp + {hash_even, hash_odd};
			key_long = 1'b1;
		end
		key_fp = key_fp ^ (64'(b) << (8 * lane));
		if (!lane[0]) begin
			hash_even = (hash_even + 32'(b)) * HASH_MUL_EVEN;
		end else begin
			hash_odd = (hash_odd + 32'(b)) * HASH_MUL_ODD;
		end
		lane        = lane + 3'd1;
		key_started = 1'b1;
	endfunction

	function automatic logic [FP_W-1:0] slot_at(input int unsigned addr);
		return bucket_mirror.exists(addr) ? bucket_mirror[addr] : '0;
	endfunction

	// search, promote, insert or evict in one bucket row
	function automatic logic probe_bucket(input logic [FP_W-1:0] fp,
			input logic [IDX_W-1:0] idx);
		int unsigned base;
		int          lock;
		int          j;
		logic [FP_W-1:0] here;
		base = int'(idx) * WAYS;
		lock = cfg_lock_half ? WAYS / 2 : 0;
		for (j = 0; j < WAYS; j++) begin
			here = slot_at(base + j);
			if (here == '0)
				break;
			if (here == fp) begin
				if (j >= lock && j < WAYS - 1 && slot_at(base + j + 1) != '0
						&& cfg_update_enable) begin
					bucket_mirror[base + j]     = slot_at(base + j + 1);
					bucket_mirror[base + j + 1] = fp;
				end
				return 1'b1;
			end
		end
		if (cfg_update_enable) begin
			// full row: shift the unlocked part down, oldest drops out
			if (j == WAYS) begin
				for (j = lock; j < WAYS - 1; j++)
					bucket_mirror[base + j] = slot_at(base + j + 1);
				j = WAYS - 1;
			end
			bucket_mirror[base + j] = fp;
		end
		return 1'b0;
	endfunction

	// returns 1 when the byte closes a key, with the verdict it yields
	function automatic logic predict_verdict(input logic [7:0] b, input logic last,
			output verdict_t v);
		logic [FP_W-1:0]   fp;
		logic [HASH_W-1:0] h;
		logic [63:0]       prod;
		v = '0;
		if (b != 8'h00)
			absorb_key_byte(b);
		if (!last)
			return 1'b0;
		fp = key_fp;
		if (key_long)
			fp[63:56] = fp[63:56] | LONG_MARK;
		h = hash_even ^ hash_odd;
		prod = 64'(h) * 64'(cfg_bucket_count);
		v.bucket_index = prod[47:32];
		v.is_duplicate = probe_bucket(fp, prod[47:32]);
		clear_key();
		return 1'b1;
	endfunction

	// ------------------------------------------------------------------
	// configuration port
	// ------------------------------------------------------------------
	task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
		logic [BC_W-1:0] bc;
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (idx)
			REG_BUCKET_COUNT: begin
				bc = value[BC_W-1:0];
				cfg_bucket_count = (bc > BC_MAX) ? BC_MAX : bc;
			end
			REG_LOCK_HALF:     cfg_lock_half = value[0];
			REG_UPDATE_ENABLE: cfg_update_enable = value[0];
			default: ;
		endcase
	endtask

	// ------------------------------------------------------------------
	// key channel: one byte per call, valid left high for the next call
	// ------------------------------------------------------------------
	task automatic send_byte(input logic [7:0] b, input logic last, input logic fixed,
			input verdict_t fixed_verdict);
		int       gap;
		verdict_t v;
		if (send_count % 40 == 0)
			send_calm = ($urandom_range(0, 2) == 0);
		send_count++;
		if (squeeze_left > 0) begin
			squeeze_left--;
			gap = 0;
		end else begin
			gap = send_calm ? 0 : $urandom_range(0, MAX_WAIT);
		end
		if (gap > 0) begin
			key_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		key_if.valid     <= 1'b1;
		key_if.key_byte  <= b;
		key_if.last_byte <= last;
		@(posedge clk);
		while (!key_if.ready) @(posedge clk);
		// transfer took place at this edge
		bytes_sent++;
		if (predict_verdict(b, last, v))
			pending_verdicts.push_back(fixed ? fixed_verdict : v);
	endtask

	// mostly clean keys from the pool or fresh ones, some with zero noise
	task automatic build_key();
		int r;
		int n;
		int slot;
		int k;
		int style;
		key_seq.delete();
		r = $urandom_range(0, 99);
		if (pool_fill > 0 && r < 40) begin
			slot = $urandom_range(0, pool_fill - 1);
		end else begin
			n = ($urandom_range(0, 4) == 0) ? $urandom_range(7, KEY_MAX)
				: $urandom_range(1, 6);
			if (pool_fill < POOL_KEYS) begin
				slot = pool_fill;
				pool_fill++;
			end else begin
				slot = $urandom_range(0, POOL_KEYS - 1);
			end
			pool_len[slot] = n;
			for (k = 0; k < n; k++)
				pool_key[slot][k] = 8'($urandom_range(1, 255));
		end
		n = pool_len[slot];
		// style: 0 clean, 1 zero fillers, 2 closed by zero byte, 3 empty key
		style = (r >= 88) ? $urandom_range(1, 3) : 0;
		if (style == 3) begin
			if ($urandom_range(0, 1) == 1)
				key_seq.push_back({1'b0, 8'h00});
			key_seq.push_back({1'b1, 8'h00});
			return;
		end
		for (k = 0; k < n; k++) begin
			if (style == 1 && $urandom_range(0, 2) == 0)
				key_seq.push_back({1'b0, 8'h00});
			key_seq.push_back({(k == n - 1 && style != 2), pool_key[slot][k]});
		end
		if (style == 2)
			key_seq.push_back({1'b1, 8'h00});
	endtask

	task automatic wait_idle();
		while (pending_verdicts.size() != 0) @(posedge clk);
		// result latency of the block, in case a key is still in flight
		repeat (8) @(posedge clk);
	endtask

	// ------------------------------------------------------------------
	// result channel: random stalls, one long hold on request
	// ------------------------------------------------------------------
	initial begin
		int       stall;
		verdict_t want;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (take_count % 30 == 0)
				take_calm = ($urandom_range(0, 2) == 0);
			if (hold_cycles > 0) begin
				stall = hold_cycles;
				hold_cycles = 0;
			end else begin
				stall = take_calm ? 0 : $urandom_range(0, MAX_WAIT);
			end
			if (stall > 0) begin
				res_if.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			res_if.ready <= 1'b1;
			@(posedge clk);
			while (!res_if.valid) @(posedge clk);
			take_count++;
			verdicts_seen++;
			if (res_if.is_duplicate)
				dups_seen++;
			if (pending_verdicts.size() == 0) begin
				report("result transfer with no verdict expected");
			end else begin
				want = pending_verdicts.pop_front();
				if (res_if.is_duplicate !== want.is_duplicate)
					report($sformatf("is_duplicate %b, expected %b",
						res_if.is_duplicate, want.is_duplicate));
				if (res_if.bucket_index !== want.bucket_index)
					report($sformatf("bucket_index %h, expected %h",
						res_if.bucket_index, want.bucket_index));
			end
		end
	end

	// ------------------------------------------------------------------
	// run limit, well beyond the slowest correct run incl. the clearing pass
	// ------------------------------------------------------------------
	initial begin
		#6000000;
		$display("== FAIL ==");
		$finish;
	end

	// ------------------------------------------------------------------
	// main sequence
	// ------------------------------------------------------------------
	initial begin
		int       i;
		int       s;
		int       k;
		int       items;
		int       waited;
		verdict_t fixed_v;

		// every input known from the start
		arst_n           <= 1'b0;
		key_if.valid     <= 1'b0;
		key_if.key_byte  <= 8'h00;
		key_if.last_byte <= 1'b0;
		res_if.ready     <= 1'b0;
		psel             <= 1'b0;
		penable          <= 1'b0;
		pwrite           <= 1'b0;
		paddr            <= '0;
		pwdata           <= '0;

		errors        = 0;
		bytes_sent    = 0;
		verdicts_seen = 0;
		dups_seen     = 0;
		settings_run  = 1;
		hold_cycles   = 0;
		squeeze_left  = 0;
		send_count    = 0;
		take_count    = 0;
		pool_fill     = 0;
		bucket_mirror.delete();
		clear_key();
		cfg_bucket_count  = BC_MAX;
		cfg_lock_half     = 1'b1;
		cfg_update_enable = 1'b1;
		plan[5].bucket_count = $urandom_range(2, 16);

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// directed part at the reset settings; the clearing pass after
		// reset simply shows up as a long stall on the key channel
		for (i = 0; i < $size(directed_rows); i++) begin
			fixed_v.is_duplicate = directed_rows[i].is_duplicate;
			fixed_v.bucket_index = directed_rows[i].bucket_index;
			send_byte(directed_rows[i].key_byte, directed_rows[i].last_byte,
				directed_rows[i].fixed, fixed_v);
		end

		// random part, one burst per register setting
		for (s = 0; s < $size(plan); s++) begin
			key_if.valid <= 1'b0;
			wait_idle();
			write_reg(REG_BUCKET_COUNT, plan[s].bucket_count);
			write_reg(REG_LOCK_HALF, {31'b0, plan[s].lock_half});
			write_reg(REG_UPDATE_ENABLE, {31'b0, plan[s].update_enable});
			settings_run++;
			if (plan[s].squeeze) begin
				// receiver holds off while bytes keep coming back to back
				hold_cycles  = LONG_HOLD;
				squeeze_left = 120;
			end
			items = 0;
			while (items < plan[s].items) begin
				build_key();
				for (k = 0; k < key_seq.size(); k++) begin
					send_byte(key_seq[k][7:0], key_seq[k][8], 1'b0, '0);
					if (key_seq[k][7:0] != 8'h00 || key_seq[k][8])
						items++;
				end
			end
		end
		key_if.valid <= 1'b0;

		// drain, then let the pipeline settle
		waited = 0;
		while (pending_verdicts.size() != 0 && waited < 5000) begin
			@(posedge clk);
			waited++;
		end
		repeat (10) @(posedge clk);
		if (pending_verdicts.size() != 0)
			report($sformatf("%0d verdicts never arrived", pending_verdicts.size()));

		$display("sent %0d key bytes, checked %0d verdicts (%0d duplicates) over %0d settings",
			bytes_sent, verdicts_seen, dups_seen, settings_run);
		$display("bucket counts zero, one, small, saturated; lock and update both ways");
		if (errors == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
